// ===== rtl/core/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants of the quadratic root solver.
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

    localparam int FIELD_W        = 16;
    localparam int OUT_W          = 36;
    localparam int COEF_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic signed [63:0] OUT_MAX = 64'sd34359738367;
    localparam logic signed [63:0] OUT_MIN = -64'sd34359738368;

    typedef enum logic [1:0] {
        KIND_DOUBLE  = 2'd0,
        KIND_TWO     = 2'd1,
        KIND_COMPLEX = 2'd2,
        KIND_INVALID = 2'd3
    } t_root_kind;

    typedef struct packed {
        logic signed [FIELD_W-1:0] coef_a;
        logic signed [FIELD_W-1:0] coef_b;
        logic signed [FIELD_W-1:0] coef_c;
    } t_in_item;

    typedef struct packed {
        t_root_kind              root_kind;
        logic signed [OUT_W-1:0] first_real;
        logic signed [OUT_W-1:0] first_imag;
        logic signed [OUT_W-1:0] second_real;
        logic signed [OUT_W-1:0] second_imag;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/core/quadratic_root_solver_unit.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit
// Roots of a*x^2 + b*x + c in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Payload
//  in       input      i_valid / o_ready   i_item (a, b, c)
//  out      output     o_valid / i_ready   o_item (kind, two complex roots)
//
//  One item per cycle while the output is accepted. Stages in order: the
//  discriminant stages, the bit-per-stage square root pipeline, the numerator
//  register, the bit-per-stage divider pipeline and the output register.
//  Synchronous active-low reset clears all valid bits.
//  The whole pipeline holds while a result sits unaccepted at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_root_solver_unit #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire qrs_pkg::t_in_item  i_item,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output qrs_pkg::t_out_item      o_item
);

    localparam int CW     = COEF_WIDTH;
    localparam int MAG_W  = 2 * CW + 1;
    localparam int NB_W   = CW + FRAC_BITS + 1;
    localparam int DEN_W  = CW + 1;
    localparam int ROOT_W = CW + 1 + FRAC_BITS;
    localparam int SUM_W  = CW + FRAC_BITS + 3;
    localparam int NUM_W  = SUM_W - 1;
    localparam int S1_W   = 2 + 1 + DEN_W + NB_W;

    logic                    w_en;

    logic                    w_d_valid;
    logic [MAG_W-1:0]        w_d_mag;
    qrs_pkg::t_root_kind     w_d_kind;
    logic                    w_d_a_neg;
    logic [DEN_W-1:0]        w_d_den;
    logic signed [NB_W-1:0]  w_d_nb;

    logic                    w_s_valid;
    logic [ROOT_W-1:0]       w_s_root;
    logic [S1_W-1:0]         w_s_side;

    qrs_pkg::t_root_kind     w_kind;
    logic                    w_a_neg;
    logic [DEN_W-1:0]        w_den;
    logic signed [NB_W-1:0]  w_nb;
    logic signed [SUM_W-1:0] w_nb_ext, w_s_ext, w_n1, w_n2, w_n1_neg, w_n2_neg;

    logic                    r_n_valid;
    logic [NUM_W-1:0]        r_num [2];
    logic [DEN_W-1:0]        r_den;
    logic                    r_neg1, r_neg2;
    qrs_pkg::t_root_kind     r_kind;

    logic                    w_q_valid;
    logic [NUM_W-1:0]        w_quo [2];
    logic [3:0]              w_q_side;
    qrs_pkg::t_root_kind     w_q_kind;
    logic signed [63:0]      w_v1, w_v2, w_q1, w_q2;
    qrs_pkg::t_out_item      n_item;

    function automatic logic signed [qrs_pkg::OUT_W-1:0] f_sat(
        input logic signed [63:0] v
    );
        logic signed [63:0] c;
        if (v > qrs_pkg::OUT_MAX) begin
            c = qrs_pkg::OUT_MAX;
        end else if (v < qrs_pkg::OUT_MIN) begin
            c = qrs_pkg::OUT_MIN;
        end else begin
            c = v;
        end
        return c[qrs_pkg::OUT_W-1:0];
    endfunction

    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    qrs_disc #(
        .COEF_WIDTH (COEF_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_valid (w_d_valid),
        .o_mag   (w_d_mag),
        .o_kind  (w_d_kind),
        .o_a_neg (w_d_a_neg),
        .o_den   (w_d_den),
        .o_nb    (w_d_nb)
    );

    qrs_sqrt #(
        .MAG_W     (MAG_W),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (S1_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d_valid),
        .i_mag   (w_d_mag),
        .i_side  ({w_d_kind, w_d_a_neg, w_d_den, w_d_nb}),
        .o_valid (w_s_valid),
        .o_root  (w_s_root),
        .o_side  (w_s_side)
    );

    assign w_kind   = qrs_pkg::t_root_kind'(w_s_side[S1_W-1 -: 2]);
    assign w_a_neg  = w_s_side[S1_W-3];
    assign w_den    = w_s_side[NB_W +: DEN_W];
    assign w_nb     = $signed(w_s_side[NB_W-1:0]);

    assign w_nb_ext = $signed({{2{w_nb[NB_W-1]}}, w_nb});
    assign w_s_ext  = $signed({2'b00, w_s_root});
    assign w_n1     = (w_kind == qrs_pkg::KIND_COMPLEX) ? w_nb_ext : (w_nb_ext - w_s_ext);
    assign w_n2     = (w_kind == qrs_pkg::KIND_COMPLEX) ? w_s_ext  : (w_nb_ext + w_s_ext);
    assign w_n1_neg = -w_n1;
    assign w_n2_neg = -w_n2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_valid <= 1'b0;
        end else if (w_en) begin
            r_n_valid <= w_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num[0] <= w_n1[SUM_W-1] ? w_n1_neg[NUM_W-1:0] : w_n1[NUM_W-1:0];
            r_num[1] <= w_n2[SUM_W-1] ? w_n2_neg[NUM_W-1:0] : w_n2[NUM_W-1:0];
            r_neg1   <= w_n1[SUM_W-1] ^ w_a_neg;
            r_neg2   <= w_n2[SUM_W-1] ^ w_a_neg;
            r_den    <= w_den;
            r_kind   <= w_kind;
        end
    end

    qrs_div #(
        .NUM_W  (NUM_W),
        .DEN_W  (DEN_W),
        .SIDE_W (4)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_n_valid),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_side  ({r_kind, r_neg1, r_neg2}),
        .o_valid (w_q_valid),
        .o_quo   (w_quo),
        .o_side  (w_q_side)
    );

    assign w_q_kind = qrs_pkg::t_root_kind'(w_q_side[3:2]);
    assign w_q1     = $signed(64'(w_quo[0]));
    assign w_q2     = $signed(64'(w_quo[1]));
    assign w_v1     = w_q_side[1] ? -w_q1 : w_q1;
    assign w_v2     = w_q_side[0] ? -w_q2 : w_q2;

    always_comb begin
        n_item           = '0;
        n_item.root_kind = w_q_kind;
        unique case (w_q_kind)
            qrs_pkg::KIND_DOUBLE: begin
                n_item.first_real  = f_sat(w_v1);
                n_item.second_real = f_sat(w_v1);
            end
            qrs_pkg::KIND_TWO: begin
                n_item.first_real  = f_sat(w_v1);
                n_item.second_real = f_sat(w_v2);
            end
            qrs_pkg::KIND_COMPLEX: begin
                n_item.first_real  = f_sat(w_v1);
                n_item.second_real = f_sat(w_v1);
                n_item.first_imag  = f_sat(-w_v2);
                n_item.second_imag = f_sat(w_v2);
            end
            qrs_pkg::KIND_INVALID: begin
                n_item.first_real  = '0;
            end
            default: begin
                n_item.first_real  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= w_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/qrs_disc.sv =====
// ----------------------------------------------------------------------------
// qrs_disc
// Two stages: products, then discriminant magnitude, root kind, -b and |2a| (1 when a is zero).
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_disc #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire qrs_pkg::t_in_item                 i_item,
    output logic                                   o_valid,
    output logic [2*COEF_WIDTH:0]                  o_mag,
    output qrs_pkg::t_root_kind                    o_kind,
    output logic                                   o_a_neg,
    output logic [COEF_WIDTH:0]                    o_den,
    output logic signed [COEF_WIDTH+FRAC_BITS:0]   o_nb
);

    localparam int CW  = COEF_WIDTH;
    localparam int PW  = 2 * CW;
    localparam int DW  = 2 * CW + 2;
    localparam int EXW = CW + qrs_pkg::FIELD_W;

    logic [EXW-1:0]         w_ext_a, w_ext_b, w_ext_c;
    logic signed [CW-1:0]   w_a, w_b, w_c;

    logic                   r_v1;
    logic signed [PW-1:0]   r_bb, r_ac;
    logic signed [CW-1:0]   r_a, r_b;

    logic signed [DW-1:0]   w_d, w_dneg;
    logic signed [CW:0]     w_a_ext, w_a_abs, w_nb0;
    qrs_pkg::t_root_kind    w_kind;

    assign w_ext_a = EXW'(i_item.coef_a);
    assign w_ext_b = EXW'(i_item.coef_b);
    assign w_ext_c = EXW'(i_item.coef_c);
    assign w_a     = $signed(w_ext_a[CW-1:0]);
    assign w_b     = $signed(w_ext_b[CW-1:0]);
    assign w_c     = $signed(w_ext_c[CW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bb <= w_b * w_b;
            r_ac <= w_a * w_c;
            r_a  <= w_a;
            r_b  <= w_b;
        end
    end

    assign w_d     = $signed({{2{r_bb[PW-1]}}, r_bb}) - $signed({r_ac, 2'b00});
    assign w_dneg  = -w_d;
    assign w_a_ext = $signed({r_a[CW-1], r_a});
    assign w_a_abs = r_a[CW-1] ? -w_a_ext : w_a_ext;
    assign w_nb0   = -$signed({r_b[CW-1], r_b});

    always_comb begin
        priority if (r_a == '0) begin
            w_kind = qrs_pkg::KIND_INVALID;
        end else if (w_d == '0) begin
            w_kind = qrs_pkg::KIND_DOUBLE;
        end else if (!w_d[DW-1]) begin
            w_kind = qrs_pkg::KIND_TWO;
        end else begin
            w_kind = qrs_pkg::KIND_COMPLEX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_mag   <= w_d[DW-1] ? w_dneg[PW:0] : w_d[PW:0];
            o_kind  <= w_kind;
            o_a_neg <= r_a[CW-1];
            o_den   <= (r_a == '0) ? (CW+1)'(1) : {w_a_abs[CW-1:0], 1'b0};
            o_nb    <= $signed({w_nb0, {FRAC_BITS{1'b0}}});
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/qrs_sqrt.sv =====
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined integer square root of mag * 2^(2*FRAC_BITS), one root bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_sqrt #(
    parameter int MAG_W     = 33,
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W    = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire logic                                i_valid,
    input  wire logic [MAG_W-1:0]                    i_mag,
    input  wire logic [SIDE_W-1:0]                   i_side,
    output logic                                     o_valid,
    output logic [(MAG_W+1)/2+FRAC_BITS-1:0]         o_root,
    output logic [SIDE_W-1:0]                        o_side
);

    localparam int HALF_W = (MAG_W + 1) / 2;
    localparam int ROOT_W = HALF_W + FRAC_BITS;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;

    logic [RAD_W-1:0]  w_rad0;
    logic [RAD_W-1:0]  r_rad  [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SIDE_W-1:0] r_side [ROOT_W];
    logic              r_val  [ROOT_W];

    assign w_rad0 = RAD_W'(i_mag) << (2 * FRAC_BITS);

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in, rem_sh, trial;
        logic [ROOT_W-1:0] root_in;
        logic [SIDE_W-1:0] side_in;
        logic              val_in, ge;

        if (k == 0) begin : g_first
            assign rad_in  = w_rad0;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = i_side;
            assign val_in  = i_valid;
        end else begin : g_next
            assign rad_in  = r_rad[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign side_in = r_side[k-1];
            assign val_in  = r_val[k-1];
        end

        assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
        assign trial  = {1'b0, root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[k] <= 1'b0;
            end else if (i_en) begin
                r_val[k] <= val_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= rad_in << 2;
                r_rem[k]  <= ge ? (rem_sh - trial) : rem_sh;
                r_root[k] <= {root_in[ROOT_W-2:0], ge};
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_val[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

`default_nettype wire

// ===== rtl/core/qrs_div.sv =====
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring divider, two numerator lanes over one divisor,
// one quotient bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div #(
    parameter int NUM_W  = 34,
    parameter int DEN_W  = 17,
    parameter int SIDE_W = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic [NUM_W-1:0]      i_num [2],
    input  wire logic [DEN_W-1:0]      i_den,
    input  wire logic [SIDE_W-1:0]     i_side,
    output logic                       o_valid,
    output logic [NUM_W-1:0]           o_quo [2],
    output logic [SIDE_W-1:0]          o_side
);

    logic [NUM_W-1:0]  r_num  [NUM_W][2];
    logic [DEN_W-1:0]  r_rem  [NUM_W][2];
    logic [NUM_W-1:0]  r_quo  [NUM_W][2];
    logic [DEN_W-1:0]  r_den  [NUM_W];
    logic [SIDE_W-1:0] r_side [NUM_W];
    logic              r_val  [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_in;
        logic              val_in;

        if (k == 0) begin : g_first
            assign den_in  = i_den;
            assign side_in = i_side;
            assign val_in  = i_valid;
        end else begin : g_next
            assign den_in  = r_den[k-1];
            assign side_in = r_side[k-1];
            assign val_in  = r_val[k-1];
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [NUM_W-1:0] num_in, quo_in;
            logic [DEN_W-1:0] rem_in;
            logic [DEN_W:0]   rem_sh, n_rem;
            logic             ge;

            if (k == 0) begin : g_first
                assign num_in = i_num[l];
                assign rem_in = '0;
                assign quo_in = '0;
            end else begin : g_next
                assign num_in = r_num[k-1][l];
                assign rem_in = r_rem[k-1][l];
                assign quo_in = r_quo[k-1][l];
            end

            assign rem_sh = {rem_in, num_in[NUM_W-1]};
            assign ge     = (rem_sh >= {1'b0, den_in});
            assign n_rem  = ge ? (rem_sh - {1'b0, den_in}) : rem_sh;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_num[k][l] <= num_in << 1;
                    r_rem[k][l] <= n_rem[DEN_W-1:0];
                    r_quo[k][l] <= {quo_in[NUM_W-2:0], ge};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[k] <= 1'b0;
            end else if (i_en) begin
                r_val[k] <= val_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k]  <= den_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid  = r_val[NUM_W-1];
    assign o_quo[0] = r_quo[NUM_W-1][0];
    assign o_quo[1] = r_quo[NUM_W-1][1];
    assign o_side   = r_side[NUM_W-1];

endmodule

`default_nettype wire

// ===== bench/tb_quadratic_root_solver_unit.sv =====
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver_unit
// Sends coefficient sets to the root solver and checks every result against
// a predictor built from the discriminant, a bit-serial square root and
// truncating division. Covers directed corner cases, random coefficient sets,
// random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_quadratic_root_solver_unit;

    localparam int FRAC = qrs_pkg::FRAC_BITS_DEF;
    localparam int LATENCY = 71;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    qrs_pkg::t_in_item  in_item;
    logic               out_valid;
    logic               out_ready;
    qrs_pkg::t_out_item out_item;

    qrs_pkg::t_out_item root_queue[$];
    int                 error_count;
    bit                 send_idle_en;
    bit                 recv_idle_en;
    int                 hold_cycles;

    quadratic_root_solver_unit u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_item  (in_item),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_item  (out_item)
    );

    always begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic [63:0] isqrt_fixed(logic [63:0] d);
        logic [63:0] root;
        logic [63:0] rem;
        logic [63:0] trial;
        logic [63:0] two;
        root = 0;
        rem  = 0;
        for (int p = 0; p < 32 + FRAC; p++) begin
            two = (p < 32) ? ((d >> (62 - 2 * p)) & 64'd3) : 64'd0;
            rem = (rem << 2) | two;
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function automatic logic signed [qrs_pkg::OUT_W-1:0] clamp_out(longint v);
        if (v > qrs_pkg::OUT_MAX) v = qrs_pkg::OUT_MAX;
        if (v < qrs_pkg::OUT_MIN) v = qrs_pkg::OUT_MIN;
        return v[qrs_pkg::OUT_W-1:0];
    endfunction

    function automatic qrs_pkg::t_out_item solve_roots(qrs_pkg::t_in_item it);
        qrs_pkg::t_out_item r;
        longint a, b, c, d, den, nb, s;
        longint r1, i1, r2, i2;
        a = it.coef_a;
        b = it.coef_b;
        c = it.coef_c;
        r1 = 0; i1 = 0; r2 = 0; i2 = 0;
        r = '0;
        if (a == 0) begin
            r.root_kind = qrs_pkg::KIND_INVALID;
            return r;
        end
        d   = b * b - 4 * a * c;
        den = 2 * a;
        nb  = -b * (longint'(1) << FRAC);
        if (d == 0) begin
            r.root_kind = qrs_pkg::KIND_DOUBLE;
            r1 = nb / den;
            r2 = r1;
        end else if (d > 0) begin
            r.root_kind = qrs_pkg::KIND_TWO;
            s  = longint'(isqrt_fixed(d));
            r1 = (nb - s) / den;
            r2 = (nb + s) / den;
        end else begin
            r.root_kind = qrs_pkg::KIND_COMPLEX;
            s  = longint'(isqrt_fixed(-d));
            r1 = nb / den;
            r2 = r1;
            i1 = -s / den;
            i2 = s / den;
        end
        r.first_real  = clamp_out(r1);
        r.first_imag  = clamp_out(i1);
        r.second_real = clamp_out(r2);
        r.second_imag = clamp_out(i2);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    // send one item; expectation is queued at acceptance
    task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        int gap;
        if (send_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item  <= '{coef_a: a, coef_b: b, coef_c: c};
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        root_queue.push_back(solve_roots(in_item));
        @(negedge clk);
    endtask

    always @(posedge clk) begin
        qrs_pkg::t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (root_queue.size() == 0) begin
                report_mismatch("unexpected item", 0, 0);
            end else begin
                want = root_queue.pop_front();
                if (out_item.root_kind !== want.root_kind)
                    report_mismatch("root_kind", out_item.root_kind, want.root_kind);
                if (out_item.first_real !== want.first_real)
                    report_mismatch("first_real", out_item.first_real, want.first_real);
                if (out_item.first_imag !== want.first_imag)
                    report_mismatch("first_imag", out_item.first_imag, want.first_imag);
                if (out_item.second_real !== want.second_real)
                    report_mismatch("second_real", out_item.second_real,
                                    want.second_real);
                if (out_item.second_imag !== want.second_imag)
                    report_mismatch("second_imag", out_item.second_imag,
                                    want.second_imag);
            end
        end
    end

    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            out_ready <= 1'b0;
        end else if (recv_idle_en && $urandom_range(0, 15) == 0) begin
            hold_cycles = $urandom_range(0, 8);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic test_corners();
        send_coefs(16'sd1, 16'sd2, 16'sd1);
        send_coefs(16'sd1, -16'sd3, 16'sd2);
        send_coefs(16'sd1, 16'sd0, 16'sd1);
        send_coefs(16'sd0, 16'sd5, 16'sd7);
        send_coefs(16'sd0, 16'sd0, 16'sd0);
        send_coefs(16'h8000, 16'h8000, 16'h8000);
        send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
        send_coefs(16'h7fff, 16'h8000, 16'h8000);
        send_coefs(16'h8000, 16'h8000, 16'h7fff);
        send_coefs(16'h8000, 16'h7fff, 16'h8000);
        send_coefs(16'h7fff, 16'h0000, 16'h8000);
        send_coefs(16'sd1, 16'h8000, 16'sd0);
        send_coefs(-16'sd1, 16'h7fff, 16'h7fff);
        send_coefs(16'sd1, 16'sd0, 16'sd0);
        send_coefs(-16'sd1, 16'sd0, 16'sd0);
        send_coefs(16'sd3, 16'sd1, 16'sd5);
        send_coefs(-16'sd2, 16'sd4, -16'sd2);
        send_coefs(16'sd7, 16'sd0, -16'sd28);
        send_coefs(16'hffff, 16'hffff, 16'hffff);
    endtask

    task automatic test_random(int count);
        logic [15:0] a, b, c;
        int k;
        for (int n = 0; n < count; n++) begin
            a = 16'($urandom);
            b = 16'($urandom);
            c = 16'($urandom);
            case ($urandom_range(0, 7))
                0: a = 16'($urandom_range(0, 8) - 4);
                1: begin
                    // build a perfect square so d is zero
                    k = $urandom_range(1, 90);
                    a = 16'(k);
                    c = 16'(k);
                    b = 16'($urandom_range(0, 1) ? 2 * k : -2 * k);
                end
                2: begin
                    a = 16'($urandom_range(0, 40) - 20);
                    b = 16'($urandom_range(0, 40) - 20);
                    c = 16'($urandom_range(0, 40) - 20);
                end
                default: ;
            endcase
            send_coefs(a, b, c);
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 200;
        test_random(150);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (root_queue.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    initial begin
        error_count  = 0;
        hold_cycles  = 0;
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_item      = '0;
        out_ready    = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_corners();
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        test_random(1200);
        test_backpressure();
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        test_random(600);
        drain();

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
